FILE: rtl/core/rnf_pkg.sv
// Shared types, constants and header helper for the RTP NAL fragmenter.
`default_nettype none

package rnf_pkg;

    // Default sizes handed to the top level
    localparam int LENGTH_BITS_DEF  = 24;
    localparam int BUFFER_BYTES_DEF = 4096;

    // Fixed field widths
    localparam int BYTE_W          = 8;
    localparam int NAL_SIZE_W      = 24;
    localparam int PAYLOAD_LIMIT_W = 13;
    localparam int SSRC_W          = 32;
    localparam int CFG_DATA_W      = 32;
    localparam int REG_IDX_W       = 2;
    localparam int SEQ_W           = 16;
    localparam int FU_CNT_W        = 2;
    localparam int EMIT_IDX_W      = 4;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_CODEC_SELECT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SSRC          = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_RTP_PT        = 2'd3;

    // Configuration reset values
    localparam logic                       CODEC_SELECT_RST  = 1'b0;
    localparam logic [PAYLOAD_LIMIT_W-1:0] PAYLOAD_LIMIT_RST = 13'd1400;
    localparam logic [SSRC_W-1:0]          SSRC_RST          = 32'hDEADBEEF;
    localparam logic [BYTE_W-1:0]          RTP_PT_RST        = 8'd96;

    // Stream framing constants
    localparam int                     PREFIX_BYTES   = 4;
    localparam logic [EMIT_IDX_W-1:0]  RTP_HDR_BYTES  = 4'd12;
    localparam logic [BYTE_W-1:0]      RTP_FIRST_BYTE = 8'h80;

    // FU header constants
    localparam logic [BYTE_W-1:0] H264_FU_A_TYPE  = 8'd28;
    localparam logic [BYTE_W-1:0] H264_NRI_MASK   = 8'hE0;
    localparam logic [BYTE_W-1:0] H264_TYPE_MASK  = 8'h1F;
    localparam logic [BYTE_W-1:0] H265_FU_TYPE    = 8'(49 << 1);
    localparam logic [BYTE_W-1:0] H265_KEEP_MASK  = 8'h81;
    localparam logic [BYTE_W-1:0] H265_TYPE_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] FU_START_BIT    = 8'h80;
    localparam logic [BYTE_W-1:0] FU_END_BIT      = 8'h40;
    localparam logic [FU_CNT_W-1:0] H264_FU_BYTES = 2'd2;
    localparam logic [FU_CNT_W-1:0] H265_FU_BYTES = 2'd3;

    typedef struct packed {
        logic                       codec_select;
        logic [PAYLOAD_LIMIT_W-1:0] payload_limit;
        logic [SSRC_W-1:0]          ssrc;
        logic [BYTE_W-1:0]          rtp_pt;
    } cfg_t;

    // Everything the emitter needs to send the results of one input byte
    typedef struct packed {
        logic                emit;
        logic                hdr;
        logic [SEQ_W-1:0]    seq;
        logic [FU_CNT_W-1:0] fu_cnt;
        logic [BYTE_W-1:0]   fu0;
        logic [BYTE_W-1:0]   fu1;
        logic [BYTE_W-1:0]   fu2;
        logic [BYTE_W-1:0]   data;
        logic                data_last;
    } burst_t;

    // One byte of the 12-byte RTP header; timestamp bytes are zero
    function automatic logic [BYTE_W-1:0] rtp_hdr_byte(
        input logic [EMIT_IDX_W-1:0] idx,
        input logic [SEQ_W-1:0]      seq,
        input logic [BYTE_W-1:0]     pt,
        input logic [SSRC_W-1:0]     ssrc
    );
        logic [BYTE_W-1:0] b;
        case (idx)
            4'd0:    b = RTP_FIRST_BYTE;
            4'd1:    b = pt;
            4'd2:    b = seq[15:8];
            4'd3:    b = seq[7:0];
            4'd8:    b = ssrc[31:24];
            4'd9:    b = ssrc[23:16];
            4'd10:   b = ssrc[15:8];
            4'd11:   b = ssrc[7:0];
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rnf_cfg.sv
// Configuration register file of the RTP NAL fragmenter.
`default_nettype none

module rnf_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [rnf_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [rnf_pkg::CFG_DATA_W-1:0] cfg_data,
    output rnf_pkg::cfg_t                      cfg
);
    import rnf_pkg::*;

    cfg_t cfg_reg;

    // Decode the register index and capture the write data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.codec_select  <= CODEC_SELECT_RST;
            cfg_reg.payload_limit <= PAYLOAD_LIMIT_RST;
            cfg_reg.ssrc          <= SSRC_RST;
            cfg_reg.rtp_pt        <= RTP_PT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CODEC_SELECT:  cfg_reg.codec_select  <= cfg_data[0];
                REG_PAYLOAD_LIMIT: cfg_reg.payload_limit <= cfg_data[PAYLOAD_LIMIT_W-1:0];
                REG_SSRC:          cfg_reg.ssrc          <= cfg_data[SSRC_W-1:0];
                REG_RTP_PT:        cfg_reg.rtp_pt        <= cfg_data[BYTE_W-1:0];
                default:           cfg_reg.codec_select  <= cfg_reg.codec_select;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rnf_ctrl.sv
// Per-byte packetizing control: NAL tracking, fragment decisions, burst build.
`default_nettype none

module rnf_ctrl #(
    parameter int LENGTH_BITS  = rnf_pkg::LENGTH_BITS_DEF,
    parameter int BUFFER_BYTES = rnf_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           take,
    input  wire logic [rnf_pkg::BYTE_W-1:0]     data_byte,
    input  wire logic                           nal_first,
    input  wire logic [rnf_pkg::NAL_SIZE_W-1:0] nal_size,
    input  rnf_pkg::cfg_t                       cfg,
    output rnf_pkg::burst_t                     burst
);
    import rnf_pkg::*;

    localparam int LB    = LENGTH_BITS;
    localparam int LIM_W = $clog2(BUFFER_BYTES + 1);
    localparam int MP_W  = (LIM_W > PAYLOAD_LIMIT_W) ? LIM_W : PAYLOAD_LIMIT_W;
    localparam int CMP_W = (LB > LIM_W) ? LB : LIM_W;

    typedef enum logic [1:0] {
        MODE_DROP,
        MODE_WHOLE,
        MODE_H264,
        MODE_H265
    } mode_t;

    mode_t             mode_reg,   mode_next;
    logic [SEQ_W-1:0]  seq_reg,    seq_next;
    logic [LB-1:0]     pos_reg,    pos_next;
    logic [LB-1:0]     len_reg,    len_next;
    logic [LIM_W-1:0]  chunk_reg,  chunk_next;
    logic [LIM_W-1:0]  cmax_reg,   cmax_next;
    logic              ff_reg,     ff_next;
    logic [BYTE_W-1:0] hdr_a_reg,  hdr_a_next;
    logic [BYTE_W-1:0] hdr_b_reg,  hdr_b_next;

    // New-buffer decisions
    logic [MP_W-1:0]  mp_ext;
    logic [MP_W-1:0]  bb_ext;
    logic [LIM_W-1:0] lim_new;
    logic [LB-1:0]    len_in;
    logic [LB-1:0]    psize_new;
    logic             fits_whole;
    logic             h264_ok;
    logic             h265_ok;
    mode_t            mode_new;

    // Running-byte terms
    logic             active;
    logic             past_prefix;
    logic             q_zero;
    logic             q_one;
    logic             at_end;
    logic [LB-1:0]    remain;
    logic             end_frag;
    logic [LIM_W-1:0] chunk_inc;
    logic             chunk_full;
    logic [BYTE_W-1:0] start_bit;
    logic [BYTE_W-1:0] end_bit;

    // Work out the mode and fragment limit of a new buffer
    always_comb
    begin
        mp_ext     = MP_W'(cfg.payload_limit);
        bb_ext     = MP_W'(BUFFER_BYTES);
        lim_new    = (mp_ext > bb_ext) ? LIM_W'(bb_ext) : LIM_W'(mp_ext);
        len_in     = LB'(nal_size);
        psize_new  = len_in - LB'(PREFIX_BYTES);
        fits_whole = CMP_W'(psize_new) <= CMP_W'(lim_new);
        h264_ok    = (psize_new > LB'(1)) && (lim_new > LIM_W'(2));
        h265_ok    = (psize_new > LB'(2)) && (lim_new > LIM_W'(3));
        if (len_in <= LB'(PREFIX_BYTES))
            mode_new = MODE_DROP;
        else if (fits_whole)
            mode_new = MODE_WHOLE;
        else if (cfg.codec_select)
            mode_new = h265_ok ? MODE_H265 : MODE_DROP;
        else
            mode_new = h264_ok ? MODE_H264 : MODE_DROP;
    end

    // Position tests for a byte within the current buffer
    always_comb
    begin
        active      = (mode_reg != MODE_DROP) && (pos_reg < len_reg);
        past_prefix = pos_reg >= LB'(PREFIX_BYTES);
        q_zero      = pos_reg == LB'(PREFIX_BYTES);
        q_one       = pos_reg == LB'(PREFIX_BYTES + 1);
        at_end      = pos_reg == (len_reg - LB'(1));
        remain      = len_reg - pos_reg;
        end_frag    = CMP_W'(remain) <= CMP_W'(cmax_reg);
        chunk_inc   = chunk_reg + LIM_W'(1);
        chunk_full  = chunk_inc >= cmax_reg;
        start_bit   = ff_reg ? FU_START_BIT : '0;
        end_bit     = end_frag ? FU_END_BIT : '0;
    end

    // Build the burst and the next state for the offered byte
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        chunk_next = chunk_reg;
        cmax_next  = cmax_reg;
        ff_next    = ff_reg;
        hdr_a_next = hdr_a_reg;
        hdr_b_next = hdr_b_reg;
        burst      = '0;
        burst.seq  = seq_reg;
        burst.data = data_byte;

        if (nal_first)
        begin
            // The first byte is always prefix and sends nothing
            mode_next  = mode_new;
            len_next   = len_in;
            pos_next   = LB'(1);
            chunk_next = '0;
            ff_next    = 1'b1;
            cmax_next  = lim_new - (cfg.codec_select ? LIM_W'(3) : LIM_W'(2));
        end
        else if (active)
        begin
            pos_next = pos_reg + LB'(1);
            if (past_prefix)
            begin
                unique case (mode_reg)
                    MODE_WHOLE:
                    begin
                        burst.emit      = 1'b1;
                        burst.hdr       = q_zero;
                        burst.data_last = at_end;
                    end
                    MODE_H264, MODE_H265:
                    begin
                        if (q_zero)
                            hdr_a_next = data_byte;
                        else if (q_one && (mode_reg == MODE_H265))
                            hdr_b_next = data_byte;
                        else
                        begin
                            burst.emit = 1'b1;
                            burst.hdr  = chunk_reg == '0;
                            if (mode_reg == MODE_H265)
                            begin
                                burst.fu_cnt = H265_FU_BYTES;
                                burst.fu0    = (hdr_a_reg & H265_KEEP_MASK) | H265_FU_TYPE;
                                burst.fu1    = hdr_b_reg;
                                burst.fu2    = ((hdr_a_reg >> 1) & H265_TYPE_MASK)
                                               | start_bit | end_bit;
                            end
                            else
                            begin
                                burst.fu_cnt = H264_FU_BYTES;
                                burst.fu0    = (hdr_a_reg & H264_NRI_MASK) | H264_FU_A_TYPE;
                                burst.fu1    = (hdr_a_reg & H264_TYPE_MASK)
                                               | start_bit | end_bit;
                            end
                            // Close the fragment when full or at the end of the NAL
                            if (chunk_full || at_end)
                            begin
                                burst.data_last = 1'b1;
                                chunk_next      = '0;
                                ff_next         = 1'b0;
                            end
                            else
                                chunk_next = chunk_inc;
                        end
                    end
                    default:
                    begin
                        burst.emit = 1'b0;
                    end
                endcase
                if (!burst.hdr)
                    burst.fu_cnt = '0;
            end
        end

        seq_next = burst.hdr ? seq_reg + SEQ_W'(1) : seq_reg;
    end

    // Hold the buffer state; advance only on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_DROP;
            seq_reg   <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            chunk_reg <= '0;
            cmax_reg  <= '0;
            ff_reg    <= 1'b1;
            hdr_a_reg <= '0;
            hdr_b_reg <= '0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            seq_reg   <= seq_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            chunk_reg <= chunk_next;
            cmax_reg  <= cmax_next;
            ff_reg    <= ff_next;
            hdr_a_reg <= hdr_a_next;
            hdr_b_reg <= hdr_b_next;
        end
    end

    // Each RTP header consumes exactly one sequence number
    assert property (@(posedge clk) disable iff (!rst_n)
        take && burst.hdr |=> seq_reg == $past(seq_reg) + SEQ_W'(1))
        else $error("sequence number did not advance after a header");

    // A fragment never grows past its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_H264 || mode_reg == MODE_H265) |-> chunk_reg < cmax_reg)
        else $error("fragment position beyond the fragment limit");

endmodule

`default_nettype wire

FILE: rtl/core/rnf_emit.sv
// Result stage: serialises one burst of RTP header, FU header and data bytes.
`default_nettype none

module rnf_emit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    input  rnf_pkg::burst_t                 burst,
    input  rnf_pkg::cfg_t                   cfg,
    input  wire logic                       out_stall,
    output logic                            out_valid,
    output logic [rnf_pkg::BYTE_W-1:0]      out_byte,
    output logic                            packet_first,
    output logic                            packet_last,
    output logic                            run_last,
    output logic                            busy
);
    import rnf_pkg::*;

    logic                  valid_reg;
    logic [EMIT_IDX_W-1:0] idx_reg;
    logic [EMIT_IDX_W-1:0] last_reg;
    burst_t                burst_reg;
    logic                  pop;
    logic                  at_last;

    assign pop     = valid_reg && !out_stall;
    assign at_last = idx_reg == last_reg;
    // Busy while a burst is in flight, unless its final byte leaves in this cycle
    assign busy    = valid_reg && !(pop && at_last);

    // Track the burst in flight and step through its bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            last_reg  <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
            last_reg  <= burst.hdr ? RTP_HDR_BYTES + EMIT_IDX_W'(burst.fu_cnt) : '0;
        end
        else if (pop)
        begin
            if (at_last)
                valid_reg <= 1'b0;
            idx_reg <= idx_reg + EMIT_IDX_W'(1);
        end
    end

    // Hold the burst payload
    always_ff @(posedge clk)
    begin
        if (load)
            burst_reg <= burst;
    end

    // Select the byte at the current position
    always_comb
    begin
        if (at_last)
            out_byte = burst_reg.data;
        else if (idx_reg < RTP_HDR_BYTES)
            out_byte = rtp_hdr_byte(idx_reg, burst_reg.seq, cfg.rtp_pt, cfg.ssrc);
        else
        begin
            case (idx_reg[1:0])
                2'd0:    out_byte = burst_reg.fu0;
                2'd1:    out_byte = burst_reg.fu1;
                default: out_byte = burst_reg.fu2;
            endcase
        end
    end

    assign out_valid    = valid_reg;
    assign packet_first = burst_reg.hdr && (idx_reg == '0);
    assign packet_last  = at_last && burst_reg.data_last;
    assign run_last     = at_last;

    // A new burst is loaded only into a free or draining stage
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || (pop && at_last)))
        else $error("burst loaded over one still in flight");

    // The byte position never runs past the end of its burst
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> idx_reg <= last_reg)
        else $error("byte position beyond burst end");

endmodule

`default_nettype wire

FILE: rtl/core/rtp_nal_fragmenter_core.sv
// An accepted byte's first result is registered and appears in the cycle after acceptance.
// Throughput, while out_stall is low: one output byte per cycle from the result stage; a
// byte with n results holds the input until its last result leaves (n is 1 for data, 13
// to 16 at a packet start), and bytes that send nothing or one byte are taken every cycle.
// Reset (rst_n, asynchronous, active low) restores register defaults, sequence 0, drop mode.
`default_nettype none

module rtp_nal_fragmenter_core #(
    parameter int LENGTH_BITS  = rnf_pkg::LENGTH_BITS_DEF,
    parameter int BUFFER_BYTES = rnf_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [rnf_pkg::REG_IDX_W-1:0]   cfg_index,
    input  wire logic [rnf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [rnf_pkg::BYTE_W-1:0]      data_byte,
    input  wire logic                            nal_first,
    input  wire logic [rnf_pkg::NAL_SIZE_W-1:0]  nal_size,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [rnf_pkg::BYTE_W-1:0]           out_byte,
    output logic                                 packet_first,
    output logic                                 packet_last,
    output logic                                 run_last
);
    import rnf_pkg::*;

    cfg_t   cfg;
    burst_t burst;
    logic   take;
    logic   busy;

    // Accept an input transaction whenever the result stage can take its burst
    assign in_stall = busy;
    assign take     = in_valid && !busy;

    rnf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rnf_ctrl #(
        .LENGTH_BITS  (LENGTH_BITS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .nal_first (nal_first),
        .nal_size  (nal_size),
        .cfg       (cfg),
        .burst     (burst)
    );

    rnf_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take && burst.emit),
        .burst        (burst),
        .cfg          (cfg),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .packet_first (packet_first),
        .packet_last  (packet_last),
        .run_last     (run_last),
        .busy         (busy)
    );

endmodule

`default_nettype wire
